// ===== hw/rtl/gcdb_pkg.sv =====
// ----------------------------------------------------------------------------
// gcdb_pkg
// Shared constants and elaboration-time helpers for the great-circle distance
// and bearing datapath.
// ----------------------------------------------------------------------------
package gcdb_pkg;

  localparam int unsigned CORDIC_STAGES = 32;
  localparam int unsigned ROT_LAT       = CORDIC_STAGES + 2;
  localparam int unsigned VEC_LAT       = CORDIC_STAGES + 1;
  localparam int unsigned PIPE_LAT      = 3 * CORDIC_STAGES + 14;

  // Width of the Q30 operands that enter a vectoring lane.
  localparam int unsigned Q30W = 34;

  localparam int unsigned DIST_W = 31;
  localparam int unsigned BEAR_W = 16;

  localparam logic signed [63:0] PI_Q60      = 64'sh3243F6A8885A308D;
  localparam logic signed [63:0] HALF_PI_Q60 = PI_Q60 >>> 1;
  localparam logic signed [63:0] TWO_PI_Q60  = PI_Q60 <<< 1;

  localparam logic [127:0] HALF_TURN = 128'd1800000000;

  // Scale from 1e-7 degree to Q60 radians with 62 fraction bits, rounded up.
  localparam logic [127:0] RAD_C =
    ((128'(PI_Q60) << 62) + HALF_TURN - 128'd1) / HALF_TURN;

  localparam logic [63:0] BEAR_DIV  = 64'(PI_Q60) / 64'd18000;
  localparam logic [63:0] BEAR_HALF = BEAR_DIV >> 1;
  localparam logic [BEAR_W-1:0] BEAR_WRAP = 16'd36000;

  localparam logic [DIST_W-1:0] DIST_MAX     = 31'h7FFFFFFF;
  localparam logic [29:0]       R100_RESET   = 30'd637279500;

  // Restoring division, used only while the design is elaborated.
  function automatic logic [127:0] udiv(input logic [127:0] n, input logic [127:0] d);
    logic [127:0] r;
    logic [127:0] q;
    r = '0;
    q = '0;
    for (int k = 127; k >= 0; k--) begin
      r = {r[126:0], n[k]};
      if (r >= d) begin
        r    = r - d;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q60: pi/4 for the first step, truncated series otherwise.
  function automatic logic signed [63:0] atan_q60(input int i);
    logic signed [63:0] sum_v;
    logic signed [63:0] term;
    int e;
    sum_v = '0;
    if (i == 0) begin
      return PI_Q60 >>> 2;
    end
    for (int k = 0; k < 32; k++) begin
      e = 60 - i * (2 * k + 1);
      if (e >= 0) begin
        term = 64'(udiv(128'd1 << e, 128'(2 * k + 1)));
        if ((k & 1) != 0) begin
          sum_v = sum_v - term;
        end else begin
          sum_v = sum_v + term;
        end
      end
    end
    return sum_v;
  endfunction

  // CORDIC gain in Q40, found by vectoring the unit vector.
  function automatic logic [63:0] cordic_gain();
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    x = 64'sd1 <<< 40;
    y = '0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (!y[63]) begin
        x = x + dx;
        y = y - dy;
      end else begin
        x = x - dx;
        y = y + dy;
      end
    end
    return x;
  endfunction

  localparam logic [63:0] CORDIC_G = cordic_gain();
  localparam logic [63:0] KINV40 =
    64'(udiv((128'd1 << 80) + 128'(CORDIC_G >> 1), 128'(CORDIC_G)));

  localparam logic signed [20:0] KINV_HI = signed'(21'(KINV40 >> 20));
  localparam logic signed [20:0] KINV_LO = signed'({1'b0, KINV40[19:0]});

endpackage

// ===== hw/rtl/gcdb_rotate.sv =====
// ----------------------------------------------------------------------------
// gcdb_rotate
// Pipelined rotation-mode CORDIC giving sine and cosine in Q30 of a Q60 angle.
// ----------------------------------------------------------------------------
module gcdb_rotate import gcdb_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [63:0] z_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  logic signed [63:0] x_q   [CORDIC_STAGES+1];
  logic signed [63:0] y_q   [CORDIC_STAGES+1];
  logic signed [63:0] z_q   [CORDIC_STAGES+1];
  logic               neg_q [CORDIC_STAGES+1];
  logic signed [63:0] z_f;
  logic               neg_f;
  logic signed [31:0] sin_q;
  logic signed [31:0] cos_q;
  logic signed [31:0] cos_r;

  // Fold angles beyond a quarter turn back into range; cosine flips sign.
  always_comb begin
    z_f   = z_i;
    neg_f = 1'b0;
    if (z_i > HALF_PI_Q60) begin
      z_f   = PI_Q60 - z_i;
      neg_f = 1'b1;
    end else if (z_i < -HALF_PI_Q60) begin
      z_f   = -PI_Q60 - z_i;
      neg_f = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= signed'(KINV40);
      y_q[0]   <= '0;
      z_q[0]   <= z_f;
      neg_q[0] <= neg_f;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [63:0] ATAN = atan_q60(i);
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][63]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - ATAN;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + ATAN;
        end
        neg_q[i+1] <= neg_q[i];
      end
    end
  end

  assign cos_r = 32'((x_q[CORDIC_STAGES] + 64'sd512) >>> 10);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= 32'((y_q[CORDIC_STAGES] + 64'sd512) >>> 10);
      cos_q <= neg_q[CORDIC_STAGES] ? -cos_r : cos_r;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ===== hw/rtl/gcdb_vector.sv =====
// ----------------------------------------------------------------------------
// gcdb_vector
// Pipelined vectoring-mode CORDIC giving atan2 in Q60 and the gained
// magnitude in Q40 of a Q30 vector.
// ----------------------------------------------------------------------------
module gcdb_vector import gcdb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [Q30W-1:0] x_i,
  input  logic signed [Q30W-1:0] y_i,
  output logic signed [63:0]    ang_o,
  output logic signed [63:0]    mag_o
);

  logic signed [63:0] x_q    [CORDIC_STAGES+1];
  logic signed [63:0] y_q    [CORDIC_STAGES+1];
  logic signed [63:0] z_q    [CORDIC_STAGES+1];
  logic               zero_q [CORDIC_STAGES+1];
  logic signed [63:0] x_f;
  logic signed [63:0] y_f;
  logic signed [63:0] z_f;
  logic signed [63:0] x_e;
  logic signed [63:0] y_e;

  assign x_e = 64'(x_i) <<< 10;
  assign y_e = 64'(y_i) <<< 10;

  // Vectors in the left half plane are turned by half a turn first.
  always_comb begin
    x_f = x_e;
    y_f = y_e;
    z_f = '0;
    if (x_e[63]) begin
      z_f = y_e[63] ? -PI_Q60 : PI_Q60;
      x_f = -x_e;
      y_f = -y_e;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x_f;
      y_q[0]    <= y_f;
      z_q[0]    <= z_f;
      zero_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [63:0] ATAN = atan_q60(i);
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_q[i][63]) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + ATAN;
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - ATAN;
        end
        zero_q[i+1] <= zero_q[i];
      end
    end
  end

  // The zero vector has angle and magnitude zero.
  assign ang_o = zero_q[CORDIC_STAGES] ? '0 : z_q[CORDIC_STAGES];
  assign mag_o = zero_q[CORDIC_STAGES] ? '0 : x_q[CORDIC_STAGES];

endmodule

// ===== hw/rtl/great_circle_distance_bearing.sv =====
// ----------------------------------------------------------------------------
// great_circle_distance_bearing
// Great-circle distance and initial bearing from a position to a waypoint.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                     Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready   position pair, 128 bits
//   m_axis    out        m_axis_tvalid/m_axis_tready   distance and bearing, 48
//   cfg       in         cfg_we_i                      earth radius, 23 bits
//
// One transaction is accepted per clock cycle while the output buffer is not
// full. Data reach the output buffer through the rotation lanes and then the
// two vectoring lanes, which stand in series.
// Reset clears the valid bits and the output buffer and loads the default
// earth radius. A two-entry output buffer takes results while the sink
// stalls; the pipeline holds only while that buffer is full, so the input
// ready comes from the buffer count and never from the output ready.
//
// The datapath converts the three angles to Q60 radians, takes sine and
// cosine of both latitudes and of the longitude difference in three parallel
// rotation lanes, forms the spherical terms, and then vectors twice: once for
// the bearing and the magnitude of (a, b), and once for the central angle. The
// bearing is divided down to hundredths of a degree by a restoring divider
// that runs alongside the second vectoring lane.
// ----------------------------------------------------------------------------
module great_circle_distance_bearing import gcdb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [22:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [30:0] here_lat, [62:31] here_lon, [93:63] target_lat, [125:94] target_lon
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [30:0] distance_cm, [46:31] bearing_centideg
  output logic [47:0]  m_axis_tdata
);

  // Rounded Q30 product, shared by all the spherical terms.
  function automatic logic signed [33:0] mul30(input logic signed [33:0] a,
                                               input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b + 68'sd536870912;
    return p[63:30];
  endfunction

  logic en;
  logic [PIPE_LAT-1:0] vld_q;
  logic [29:0] r100_q;

  // The radius is held already multiplied by 100 for the centimetre scale.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r100_q <= R100_RESET;
    end else if (cfg_we_i) begin
      r100_q <= 30'({cfg_wdata_i, 6'b0}) + 30'({cfg_wdata_i, 5'b0}) +
                30'({cfg_wdata_i, 2'b0});
    end
  end

  // Valid bits march with the data; everything moves on the same enable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], s_axis_tvalid};
    end
  end

  assign s_axis_tready = en;

  // Stage one: unpack, wrap the longitude difference, split sign and size.
  logic signed [33:0] ang [3];
  logic signed [33:0] dlon_raw;
  logic [30:0] p1_mag_q [3];
  logic        p1_neg_q [3];

  always_comb begin
    ang[0]   = 34'(signed'(s_axis_tdata[30:0]));
    ang[1]   = 34'(signed'(s_axis_tdata[93:63]));
    dlon_raw = 34'(signed'(s_axis_tdata[125:94])) - 34'(signed'(s_axis_tdata[62:31]));
    ang[2]   = dlon_raw;
    if (dlon_raw > 34'sd1800000000) begin
      ang[2] = dlon_raw - 34'sd3600000000;
    end else if (dlon_raw < -34'sd1800000000) begin
      ang[2] = dlon_raw + 34'sd3600000000;
    end
  end

  // Stages two and three: scale to Q60 radians through three partial products.
  logic signed [63:0] p3_z_q [3];
  logic signed [31:0] sin_w  [3];
  logic signed [31:0] cos_w  [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic signed [33:0] mag_full;
    logic [62:0]  pp_q [3];
    logic [127:0] sum_w;
    logic [63:0]  res_w;

    assign mag_full = ang[k][33] ? -ang[k] : ang[k];

    always_ff @(posedge clk_i) begin
      if (en) begin
        p1_mag_q[k] <= mag_full[30:0];
        p1_neg_q[k] <= ang[k][33];
      end
    end

    for (genvar j = 0; j < 3; j++) begin : g_pp
      always_ff @(posedge clk_i) begin
        if (en) begin
          pp_q[j] <= 63'(p1_mag_q[k]) * 63'(RAD_C[32*j +: 32]);
        end
      end
    end

    logic neg2_q;
    always_ff @(posedge clk_i) begin
      if (en) begin
        neg2_q <= p1_neg_q[k];
      end
    end

    assign sum_w = 128'(pp_q[0]) + (128'(pp_q[1]) << 32) + (128'(pp_q[2]) << 64) +
                   (128'd1 << 61);
    assign res_w = sum_w[125:62];

    always_ff @(posedge clk_i) begin
      if (en) begin
        p3_z_q[k] <= neg2_q ? -signed'(res_w) : signed'(res_w);
      end
    end

    gcdb_rotate u_rot (
      .clk_i (clk_i),
      .en_i  (en),
      .z_i   (p3_z_q[k]),
      .sin_o (sin_w[k]),
      .cos_o (cos_w[k])
    );
  end

  // Stages four to six: the spherical terms a, b and d.
  logic signed [33:0] s1, c1, s2, c2, sd, cd;
  assign s1 = 34'(sin_w[0]);
  assign c1 = 34'(cos_w[0]);
  assign s2 = 34'(sin_w[1]);
  assign c2 = 34'(cos_w[1]);
  assign sd = 34'(sin_w[2]);
  assign cd = 34'(cos_w[2]);

  logic signed [33:0] p4_c1s2_q, p4_s1c2_q, p4_s1s2_q, p4_c1c2_q, p4_b_q, p4_cd_q;
  logic signed [33:0] p5_c1s2_q, p5_s1s2_q, p5_t1_q, p5_t2_q, p5_b_q;
  logic signed [33:0] p6_a_q, p6_den_q, p6_b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_c1s2_q <= mul30(c1, s2);
      p4_s1c2_q <= mul30(s1, c2);
      p4_s1s2_q <= mul30(s1, s2);
      p4_c1c2_q <= mul30(c1, c2);
      p4_b_q    <= mul30(sd, c2);
      p4_cd_q   <= cd;
      p5_t1_q   <= mul30(p4_s1c2_q, p4_cd_q);
      p5_t2_q   <= mul30(p4_c1c2_q, p4_cd_q);
      p5_c1s2_q <= p4_c1s2_q;
      p5_s1s2_q <= p4_s1s2_q;
      p5_b_q    <= p4_b_q;
      p6_a_q    <= p5_c1s2_q - p5_t1_q;
      p6_den_q  <= p5_s1s2_q + p5_t2_q;
      p6_b_q    <= p5_b_q;
    end
  end

  // First vectoring lane: bearing angle and the magnitude of (a, b).
  logic signed [63:0] th_w, m_w;

  gcdb_vector u_vec_brg (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (p6_a_q),
    .y_i   (p6_b_q),
    .ang_o (th_w),
    .mag_o (m_w)
  );

  logic signed [33:0] den_dly_q [VEC_LAT];
  always_ff @(posedge clk_i) begin
    if (en) begin
      den_dly_q[0] <= p6_den_q;
      for (int i = 1; i < VEC_LAT; i++) begin
        den_dly_q[i] <= den_dly_q[i-1];
      end
    end
  end

  // Stages seven and eight: wrap the bearing, remove the CORDIC gain.
  logic signed [63:0] th_pos;
  logic signed [44:0] m45;
  logic [63:0]        p7_num_q, p8_num_q;
  logic signed [65:0] p7_ph_q, p7_pl_q;
  logic signed [33:0] p7_den_q, p8_den_q, p8_gm_q;
  logic signed [65:0] gt_w;

  assign th_pos = th_w[63] ? th_w + TWO_PI_Q60 : th_w;
  assign m45    = m_w[44:0];
  assign gt_w   = p7_ph_q + (p7_pl_q >>> 20) + 66'sd536870912;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p7_num_q <= unsigned'(th_pos) + BEAR_HALF;
      p7_ph_q  <= m45 * KINV_HI;
      p7_pl_q  <= m45 * KINV_LO;
      p7_den_q <= den_dly_q[VEC_LAT-1];
      p8_num_q <= p7_num_q;
      p8_gm_q  <= gt_w[63:30];
      p8_den_q <= p7_den_q;
    end
  end

  // Second vectoring lane: central angle from (d, |(a, b)|).
  logic signed [63:0] c_w;

  gcdb_vector u_vec_ang (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (p8_den_q),
    .y_i   (p8_gm_q),
    .ang_o (c_w),
    .mag_o ()
  );

  // Bearing divider beside the second lane: one quotient bit in each of the first BEAR_W stages; the rest pass it on.
  logic [63:0]       rem_q [VEC_LAT];
  logic [BEAR_W-1:0] quo_q [VEC_LAT];

  for (genvar k = 0; k < VEC_LAT; k++) begin : g_div
    logic [63:0]       rem_in, rem_out;
    logic [BEAR_W-1:0] quo_in, quo_out;
    if (k == 0) begin : g_first
      assign rem_in = p8_num_q;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
    end
    if (k < BEAR_W) begin : g_step
      localparam logic [63:0] DSH = BEAR_DIV << (BEAR_W - 1 - k);
      always_comb begin
        rem_out = rem_in;
        quo_out = quo_in;
        if (rem_in >= DSH) begin
          rem_out = rem_in - DSH;
          quo_out[BEAR_W-1-k] = 1'b1;
        end
      end
    end else begin : g_pass
      assign rem_out = rem_in;
      assign quo_out = quo_in;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[k] <= rem_out;
        quo_q[k] <= quo_out;
      end
    end
  end

  // Stages nine and ten: scale the central angle to centimetres.
  logic signed [63:0] c_pos;
  logic [32:0]        ch_w;
  logic [29:0]        cl_w;
  logic [62:0]        p9_ph_q;
  logic [59:0]        p9_pl_q;
  logic [BEAR_W-1:0]  p9_brg_q, p10_brg_q;
  logic [DIST_W-1:0]  p10_dist_q;
  logic [63:0]        dsum_w;
  logic [33:0]        dist_w;

  assign c_pos = c_w[63] ? '0 : c_w;
  assign ch_w  = c_pos[62:30];
  assign cl_w  = c_pos[29:0];

  assign dsum_w = 64'(p9_ph_q) + ((64'(p9_pl_q) + 64'd536870912) >> 30) + 64'd536870912;
  assign dist_w = dsum_w[63:30];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p9_ph_q    <= 63'(ch_w) * 63'(r100_q);
      p9_pl_q    <= 60'(cl_w) * 60'(r100_q);
      p9_brg_q   <= (quo_q[VEC_LAT-1] >= BEAR_WRAP) ? '0 : quo_q[VEC_LAT-1];
      p10_dist_q <= (dist_w > 34'(DIST_MAX)) ? DIST_MAX : dist_w[DIST_W-1:0];
      p10_brg_q  <= p9_brg_q;
    end
  end

  // Two-entry output buffer.
  logic [DIST_W+BEAR_W-1:0] obuf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign en    = (cnt_q != 2'd2);
  assign push  = en & vld_q[PIPE_LAT-1];
  assign pop   = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      obuf_q[wr_ptr_q] <= {p10_brg_q, p10_dist_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {1'b0, obuf_q[rd_ptr_q]};

endmodule

// ===== hw/rtl/gcdb_checker.sv =====
// ----------------------------------------------------------------------------
// gcdb_checker
// Port-level checks on the great-circle distance and bearing block.
// ----------------------------------------------------------------------------
module gcdb_checker import gcdb_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  a_bearing_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[46:31] < BEAR_WRAP) && !m_axis_tdata[47])
    else $error("bearing out of range or padding set");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input held off while no result is waiting");

endmodule

bind great_circle_distance_bearing gcdb_checker u_gcdb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/great_circle_distance_bearing_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// great_circle_distance_bearing_checker
// Watches the input, output and radius ports of the great-circle block,
// predicts the distance and bearing of every accepted transaction in
// fixed point and compares each output transaction with the oldest forecast.
// ----------------------------------------------------------------------------
module great_circle_distance_bearing_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [22:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [47:0]  m_axis_tdata,
  output int           errors_o,
  output int           pending_o
);

  localparam int          N_STEPS   = 32;
  localparam longint      PI60      = 64'sh3243F6A8885A308D;
  localparam longint      HALF_TURN = 64'sd1800000000;

  // Bearing in the upper bits and distance in the lower, as on the bus.
  typedef struct packed {
    logic [15:0] brg_cd;
    logic [30:0] range_cm;
  } nav_fix_t;

  nav_fix_t    fix_q[$];
  longint      arc_tab[N_STEPS];
  longint      k_inv;
  logic [22:0] radius_m;
  int          errors;

  assign errors_o  = errors;
  assign pending_o = fix_q.size();

  function automatic longint q30_mul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // 1e-7 degree units to Q60 radians, rounded on the magnitude.
  function automatic longint units_to_rad(longint v);
    longint unsigned q, r, mag, res;
    q   = longint'(PI60) / 64'd1800000000;
    r   = longint'(PI60) % 64'd1800000000;
    mag = (v < 0) ? -v : v;
    res = mag * q + (mag * r + 64'd900000000) / 64'd1800000000;
    return (v < 0) ? -longint'(res) : longint'(res);
  endfunction

  function automatic longint vector_angle(longint x30, longint y30, output longint mag);
    longint x, y, z, dx, dy;
    x = x30 * 1024;
    y = y30 * 1024;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      z = (y >= 0) ? PI60 : -PI60;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < N_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arc_tab[i];
      end else begin
        x -= dx; y += dy; z -= arc_tab[i];
      end
    end
    mag = x;
    return z;
  endfunction

  task automatic rotate(longint ang, output longint s30, output longint c30);
    longint x, y, z, dx, dy;
    bit     flip;
    x = k_inv;
    y = 0;
    z = ang;
    flip = 0;
    // Fold angles beyond a quarter turn back and negate the cosine.
    if (z > (PI60 >>> 1)) begin
      z = PI60 - z; flip = 1;
    end else if (z < -(PI60 >>> 1)) begin
      z = -PI60 - z; flip = 1;
    end
    for (int i = 0; i < N_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arc_tab[i];
      end else begin
        x += dx; y -= dy; z += arc_tab[i];
      end
    end
    s30 = (y + 512) >>> 10;
    c30 = (x + 512) >>> 10;
    if (flip) c30 = -c30;
  endtask

  function automatic longint remove_gain(longint m40);
    longint kh, kl, t;
    kh = k_inv >>> 20;
    kl = k_inv & 64'hFFFFF;
    t  = m40 * kh + ((m40 * kl) >>> 20);
    return (t + (64'sd1 <<< 29)) >>> 30;
  endfunction

  task automatic predict_fix(logic [127:0] d, output nav_fix_t fix);
    longint hl, ho, tl, to, dl, s1, c1, s2, c2, sd, cd, a, b, den, m, th, c;
    longint unsigned div, cdeg, r100, ch, cl, dist_calc;
    hl = longint'($signed(d[30:0]));
    ho = longint'($signed(d[62:31]));
    tl = longint'($signed(d[93:63]));
    to = longint'($signed(d[125:94]));
    dl = to - ho;
    if (dl > HALF_TURN) dl -= 2 * HALF_TURN;
    else if (dl < -HALF_TURN) dl += 2 * HALF_TURN;
    rotate(units_to_rad(hl), s1, c1);
    rotate(units_to_rad(tl), s2, c2);
    rotate(units_to_rad(dl), sd, cd);
    a   = q30_mul(c1, s2) - q30_mul(q30_mul(s1, c2), cd);
    b   = q30_mul(sd, c2);
    den = q30_mul(s1, s2) + q30_mul(q30_mul(c1, c2), cd);
    th = vector_angle(a, b, m);
    if (th < 0) th += 2 * PI60;
    div  = longint'(PI60) / 64'd18000;
    cdeg = (longint'(th) + div / 2) / div;
    if (cdeg >= 36000) cdeg = 0;
    c = vector_angle(den, remove_gain(m), m);
    if (c < 0) c = 0;
    r100 = longint'(radius_m) * 100;
    ch   = longint'(c) >> 30;
    cl   = longint'(c) & 64'h3FFFFFFF;
    dist_calc = (ch * r100 + ((cl * r100 + (64'd1 << 29)) >> 30) + (64'd1 << 29)) >> 30;
    if (dist_calc > 64'h7FFFFFFF) dist_calc = 64'h7FFFFFFF;
    fix.range_cm = dist_calc[30:0];
    fix.brg_cd   = cdeg[15:0];
  endtask

  initial begin
    longint sum, term, g, y;
    longint unsigned gu, q1, r1;
    int e;
    arc_tab[0] = PI60 / 4;
    for (int i = 1; i < N_STEPS; i++) begin
      sum = 0;
      for (int k = 0; k < 64; k++) begin
        e = 60 - i * (2 * k + 1);
        if (e < 0) break;
        term = longint'((64'd1 << e) / longint'(2 * k + 1));
        if (k % 2) sum -= term;
        else sum += term;
      end
      arc_tab[i] = sum;
    end
    k_inv = 0;
    y = vector_angle(64'sd1 <<< 30, 0, g);
    gu = g;
    q1 = (64'd1 << 63) / gu;
    r1 = (64'd1 << 63) % gu;
    k_inv = longint'((q1 << 17) + ((r1 << 17) + gu / 2) / gu);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    nav_fix_t want, got;
    if (!rst_ni) begin
      radius_m = 23'd6372795;
      errors   = 0;
      fix_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[46:0];
        if (fix_q.size() == 0) begin
          $error("result with no transaction outstanding: %h", m_axis_tdata);
          errors++;
        end else begin
          want = fix_q.pop_front();
          if (got.range_cm !== want.range_cm) begin
            $error("distance_cm expected %0d got %0d", want.range_cm, got.range_cm);
            errors++;
          end
          if (got.brg_cd !== want.brg_cd) begin
            $error("bearing_centideg expected %0d got %0d", want.brg_cd, got.brg_cd);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_fix(s_axis_tdata, want);
        fix_q = {fix_q, want};
      end
      if (cfg_we_i) radius_m = cfg_wdata_i;
    end
  end

endmodule

// ===== tb/great_circle_distance_bearing_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// great_circle_distance_bearing_tb
// Drives position pairs into the great-circle block under several earth
// radii, with random gaps and back-pressure, and leaves all checking to the
// checker module; reports the verdict at the end.
// ----------------------------------------------------------------------------
module great_circle_distance_bearing_tb;
  import gcdb_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [22:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  int           errors;
  int           pending;

  // Stimulus controls shared with the sink process.
  bit steady_flow = 0;
  bit hold_sink   = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  great_circle_distance_bearing DUT (.*);

  great_circle_distance_bearing_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    #2000000;
    $display("great_circle_distance_bearing_tb: errors");
    $finish;
  end

  function automatic longint span(longint lo, longint hi);
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  // One position-pair transaction; a random pause may precede it unless the
  // flow is steady. The valid line is written only once per clock edge.
  task automatic send_pair(longint hla, longint hlo, longint tla, longint tlo);
    int p, gap;
    logic [30:0] a;
    logic [31:0] b;
    logic [30:0] c;
    logic [31:0] d;
    p = $urandom_range(99);
    gap = 0;
    if (!steady_flow) begin
      if (p < 20) gap = $urandom_range(1, 3);
      else if (p < 22) gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    a = 31'(hla); b = 32'(hlo); c = 31'(tla); d = 32'(tlo);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, d, c, b, a};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_all();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_radius(logic [22:0] r);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Short hops near a random point, about as many global pairs, a few with
  // latitudes anywhere in the field's range.
  task automatic random_pairs(int n);
    longint hla, hlo, tla, tlo;
    int p;
    for (int i = 0; i < n; i++) begin
      p   = $urandom_range(99);
      hla = span(-900000000, 900000000);
      hlo = span(-1800000000, 1800000000);
      if (p < 45) begin
        tla = hla + span(-1000000, 1000000);
        tlo = hlo + span(-1000000, 1000000);
        if (tlo > 2147483647 || tlo < -2147483648) tlo = hlo;
      end else if (p < 85) begin
        tla = span(-900000000, 900000000);
        tlo = span(-1800000000, 1800000000);
      end else begin
        hla = longint'($signed(31'($urandom)));
        tla = longint'($signed(31'($urandom)));
        tlo = span(-1800000000, 1800000000);
      end
      send_pair(hla, hlo, tla, tlo);
    end
  endtask

  // Sink: random ready with occasional long stalls, always ready when the
  // flow is steady, and a long fixed hold when requested.
  initial begin
    int p;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_sink = 0;
      end else if (steady_flow) begin
        m_axis_tready <= 1'b1;
      end else begin
        p = $urandom_range(99);
        if (p < 70) m_axis_tready <= 1'b1;
        else if (p < 97) m_axis_tready <= 1'b0;
        else begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(20, 80)) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cases under the reset radius.
    send_pair(0, 0, 0, 0);
    send_pair(473000000, 85000000, 473000000, 85000000);
    send_pair(0, 0, 900000000, 0);
    send_pair(0, 0, -900000000, 0);
    send_pair(900000000, 0, 0, 1000000);
    send_pair(-900000000, 0, 100000000, -1234567);
    send_pair(0, 0, 0, 1800000000);
    send_pair(0, 0, 0, -1800000000);
    send_pair(0, -1800000000, 0, 1800000000);
    send_pair(0, 1800000000, 0, -1800000000);
    send_pair(10000000, 1790000000, -10000000, -1790000000);
    send_pair(0, 0, 10000000, -1);
    send_pair(0, 0, 10000000, 1);
    send_pair(-1073741824, 0, 1073741823, 0);
    send_pair(1073741823, -1800000000, -1073741824, 1800000000);
    send_pair(900000000, 1800000000, -900000000, -1800000000);
    send_pair(515000000, -1200000, 515000001, -1200000);
    send_pair(-337000000, 1512000000, 515000000, -1200000);
    drain_all();

    // Lower radius, steady flow in both directions.
    write_radius(23'd6300000);
    steady_flow = 1;
    random_pairs(300);
    steady_flow = 0;
    drain_all();

    // Upper radius; the sink holds off while items keep coming, and once
    // the source waits for every result before going on.
    write_radius(23'd6400000);
    hold_sink = 1;
    random_pairs(150);
    drain_all();
    random_pairs(150);
    drain_all();

    // Widest radius the register holds, where long arcs saturate.
    write_radius(23'h7FFFFF);
    random_pairs(250);
    drain_all();

    write_radius(23'(span(6300000, 6400000)));
    random_pairs(200);
    drain_all();

    write_radius(23'd6372795);
    random_pairs(200);
    drain_all();

    repeat (PIPE_LAT + 50) @(posedge clk_i);
    if (errors == 0) $display("great_circle_distance_bearing_tb: clean");
    else $display("great_circle_distance_bearing_tb: errors");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/gcdb_pkg.sv
hw/rtl/gcdb_rotate.sv
hw/rtl/gcdb_vector.sv
hw/rtl/great_circle_distance_bearing.sv
hw/rtl/gcdb_checker.sv
tb/great_circle_distance_bearing_checker.sv
tb/great_circle_distance_bearing_tb.sv
